FILE: hw/rtl/sbad_pkg.sv
package sbad_pkg;

  localparam int unsigned AddrW   = 24;
  localparam int unsigned DataW   = 16;
  localparam int unsigned SmpSizeW  = 25;
  localparam int unsigned ProgSizeW = 20;
  localparam int unsigned CfgIdxW   = 8;

  // bus map
  localparam logic [AddrW-1:0] RamSize   = 24'h080000;
  localparam logic [AddrW-1:0] ChipBase  = 24'h100000;
  localparam logic [AddrW-1:0] ChipSize  = 24'h001000;
  localparam logic [AddrW-1:0] CtrlBase  = 24'h400000;
  localparam logic [AddrW-1:0] ProgBase  = 24'h600000;
  localparam logic [AddrW-1:0] ProgSpan  = 24'h080000;
  localparam logic [AddrW-1:0] SmpBase   = 24'h800000;
  localparam logic [AddrW-1:0] SmpSpan   = 24'h200000;
  localparam logic [AddrW-1:0] BankABase = 24'ha00000;
  localparam logic [AddrW-1:0] BankASpan = 24'h400000;
  localparam logic [AddrW-1:0] BankBBase = 24'he00000;
  localparam logic [AddrW-1:0] BankBSpan = 24'h200000;

  // sample bank origins for default / upper banking
  localparam logic [AddrW-1:0] BankADflt  = 24'h200000;
  localparam logic [AddrW-1:0] BankAUpper = 24'h800000;
  localparam logic [AddrW-1:0] BankBDflt  = 24'h600000;
  localparam logic [AddrW-1:0] BankBUpper = 24'ha00000;

  localparam logic [SmpSizeW-1:0] BankLimit = 25'h0800000;
  localparam int unsigned         BankBit   = 5;

  typedef enum logic [2:0] {
    TGT_RAM      = 3'd0,
    TGT_PROG     = 3'd1,
    TGT_SAMPLE   = 3'd2,
    TGT_CHIP     = 3'd3,
    TGT_CTRL     = 3'd4,
    TGT_UNMAPPED = 3'd5
  } target_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_ROM_SIZE  = 8'd0,
    CFG_PROGRAM_ROM_SIZE = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [DataW-1:0] store_data;
    logic             store_enable;
    logic [1:0]       lane_mask;
    logic [AddrW-1:0] target_offset;
    target_e          target;
  } dec_res_t;

  typedef struct packed {
    logic we;
    logic bank_default;
  } bank_upd_t;

endpackage

FILE: hw/rtl/sbad_decode.sv
module sbad_decode (
  input  logic                            func_i,
  input  logic                            byte_access_i,
  input  logic [sbad_pkg::AddrW-1:0]      address_i,
  input  logic [sbad_pkg::DataW-1:0]      write_data_i,
  input  logic [sbad_pkg::SmpSizeW-1:0]   sample_rom_size_i,
  input  logic [sbad_pkg::ProgSizeW-1:0]  program_rom_size_i,
  input  logic                            bank_default_i,
  output sbad_pkg::dec_res_t              res_o,
  output sbad_pkg::bank_upd_t             bank_upd_o
);
  import sbad_pkg::*;

  logic [AddrW-1:0]     a;
  logic [1:0]           sel;
  logic [AddrW-1:0]     off_prog;
  logic [ProgSizeW-1:0] prog_lim;
  logic [ProgSizeW-1:0] prog_o;
  logic [AddrW-1:0]     chip_o;
  logic                 in_smp;
  logic [AddrW-1:0]     smp_o;
  logic [AddrW-1:0]     smp_origin;
  logic [AddrW-1:0]     smp_span;
  logic [SmpSizeW-1:0]  smp_so;
  logic [SmpSizeW-1:0]  smp_left;
  logic [AddrW-1:0]     smp_span_left;
  logic                 drop_low;
  logic [1:0]           mask;
  target_e              tgt;
  logic [AddrW-1:0]     off;

  always_comb begin
    a   = byte_access_i ? {address_i[AddrW-1:1], 1'b0} : address_i;
    sel = byte_access_i ? (address_i[0] ? 2'b01 : 2'b10) : 2'b11;

    off_prog = a - ProgBase;
    prog_o   = off_prog[ProgSizeW-1:0];
    prog_lim = (program_rom_size_i < ProgSpan[ProgSizeW-1:0]) ? program_rom_size_i
                                                               : ProgSpan[ProgSizeW-1:0];
    chip_o   = a - ChipBase;

    // pick the sample window the address falls in
    in_smp     = 1'b1;
    smp_o      = a - SmpBase;
    smp_origin = '0;
    smp_span   = SmpSpan;
    if (a >= SmpBase && a < BankABase) begin
      smp_o      = a - SmpBase;
      smp_origin = '0;
      smp_span   = SmpSpan;
    end else if (a >= BankABase && a < BankBBase) begin
      smp_o      = a - BankABase;
      smp_origin = bank_default_i ? BankADflt : BankAUpper;
      smp_span   = BankASpan;
    end else if (a >= BankBBase) begin
      smp_o      = a - BankBBase;
      smp_origin = bank_default_i ? BankBDflt : BankBUpper;
      smp_span   = BankBSpan;
    end else begin
      in_smp = 1'b0;
    end
    smp_so        = {1'b0, smp_origin} + {1'b0, smp_o};
    smp_left      = sample_rom_size_i - smp_so;
    smp_span_left = smp_span - smp_o;

    tgt      = TGT_UNMAPPED;
    off      = '0;
    drop_low = 1'b0;
    if (a < RamSize) begin
      tgt      = TGT_RAM;
      off      = a;
      drop_low = (a == RamSize - 24'd1);
    end else if (a >= ProgBase && a < ProgBase + ProgSpan) begin
      if (prog_o < prog_lim) begin
        tgt      = TGT_PROG;
        off      = {{(AddrW-ProgSizeW){1'b0}}, prog_o};
        drop_low = ((prog_lim - prog_o) == 20'd1);
      end
    end else if (in_smp) begin
      if (smp_so < sample_rom_size_i) begin
        tgt      = TGT_SAMPLE;
        off      = smp_so[AddrW-1:0];
        drop_low = (smp_left == 25'd1) || (smp_span_left == 24'd1);
      end
    end else if (a >= ChipBase && a < ChipBase + ChipSize) begin
      tgt = TGT_CHIP;
      off = {1'b0, chip_o[AddrW-1:1]};
    end else if (a >= CtrlBase && a < CtrlBase + 24'd2) begin
      tgt = TGT_CTRL;
    end

    mask = 2'b00;
    if (tgt == TGT_RAM || tgt == TGT_PROG || tgt == TGT_SAMPLE || tgt == TGT_CHIP) begin
      mask = drop_low ? (sel & 2'b10) : sel;
    end

    res_o.target        = tgt;
    res_o.target_offset = off;
    res_o.lane_mask     = mask;
    res_o.store_enable  = 1'b0;
    res_o.store_data    = '0;
    if (func_i && (tgt == TGT_RAM || tgt == TGT_CHIP) && mask != 2'b00) begin
      res_o.store_enable = 1'b1;
      if (!byte_access_i) begin
        res_o.store_data = write_data_i;
      end else if (address_i[0]) begin
        res_o.store_data = {8'h00, write_data_i[7:0]};
      end else begin
        res_o.store_data = {write_data_i[7:0], 8'h00};
      end
    end

    // banking only switches with more than 8 MB of sample ROM
    bank_upd_o.we           = func_i && (tgt == TGT_CTRL) && (sample_rom_size_i > BankLimit);
    bank_upd_o.bank_default = write_data_i[BankBit];
  end

endmodule

FILE: hw/rtl/sound_bus_address_decoder_core.sv
// An access passes two registers, the input register and then the result register.
// One access per cycle unless the output stalls; the decode is one pass between them.
// The bank control bit is applied as an access leaves the input register, so the next
// access already decodes with the new banking.
// Reset: async active low; pipeline emptied, ROM sizes 0, default banking selected.
module sound_bus_address_decoder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sbad_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sbad_pkg::SmpSizeW-1:0]  cfg_data_i,
  // access in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // address[23:0], write_data[39:24]
  input  logic [1:0]                     s_axis_tuser,  // func[0], byte_access[1]
  // decode result out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [47:0]                    m_axis_tdata,  // target_offset[23:0],
                                                        // lane_mask[25:24], store_enable[26],
                                                        // store_data[42:27], zero[47:43]
  output logic [2:0]                     m_axis_tuser   // target[2:0]
);
  import sbad_pkg::*;

  logic [SmpSizeW-1:0]  smp_size_q;
  logic [ProgSizeW-1:0] prog_size_q;
  logic                 bank_q;

  logic             in_valid_q;
  logic             in_func_q;
  logic             in_byte_q;
  logic [AddrW-1:0] in_addr_q;
  logic [DataW-1:0] in_wd_q;

  logic             out_valid_q;
  dec_res_t         out_res_q;

  dec_res_t  dec_res;
  bank_upd_t bank_upd;
  logic      out_ready;
  logic      in_ready;
  logic      advance;

  assign cfg_ready_o = 1'b1;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || out_ready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_size_q  <= '0;
      prog_size_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_ROM_SIZE:  smp_size_q  <= cfg_data_i;
        CFG_PROGRAM_ROM_SIZE: prog_size_q <= cfg_data_i[ProgSizeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_func_q <= s_axis_tuser[0];
      in_byte_q <= s_axis_tuser[1];
      in_addr_q <= s_axis_tdata[AddrW-1:0];
      in_wd_q   <= s_axis_tdata[AddrW+DataW-1:AddrW];
    end
  end

  sbad_decode u_decode (
    .func_i             (in_func_q),
    .byte_access_i      (in_byte_q),
    .address_i          (in_addr_q),
    .write_data_i       (in_wd_q),
    .sample_rom_size_i  (smp_size_q),
    .program_rom_size_i (prog_size_q),
    .bank_default_i     (bank_q),
    .res_o              (dec_res),
    .bank_upd_o         (bank_upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b1;
    end else if (advance && bank_upd.we) begin
      bank_q <= bank_upd.bank_default;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= dec_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.target;
  assign m_axis_tdata  = {5'b0, out_res_q.store_data, out_res_q.store_enable,
                          out_res_q.lane_mask, out_res_q.target_offset};

endmodule

FILE: dv/tb_sound_bus_address_decoder_core.sv
`timescale 1ns / 1ps

module tb_sound_bus_address_decoder_core;
  import sbad_pkg::*;

  localparam logic FnRead   = 1'b0;
  localparam logic FnWrite  = 1'b1;
  localparam logic AccWord  = 1'b0;
  localparam logic AccByte  = 1'b1;
  localparam int unsigned PhaseItems = 241;

  // Tracks ROM sizes and banking, predicts each decode, and checks results in order.
  class decode_checker;
    logic [SmpSizeW-1:0]  smp_size  = '0;
    logic [ProgSizeW-1:0] prog_size = '0;
    logic                 bank_dflt = 1'b1;
    dec_res_t             pending_decodes[$];
    int unsigned          n_err = 0;
    int unsigned          n_checked = 0;
    int unsigned          n_per_tgt[6] = '{default: 0};

    function void map_sample(input int unsigned so, input int unsigned span,
                             inout target_e tgt, inout int unsigned off,
                             inout int unsigned room);
      if (so >= smp_size) return;
      tgt  = TGT_SAMPLE;
      off  = so;
      room = (span < smp_size - so) ? span : smp_size - so;
    endfunction

    function void note_access(input logic wr, input logic byte_acc,
                              input logic [AddrW-1:0] addr, input logic [DataW-1:0] wd);
      dec_res_t    res;
      target_e     tgt;
      int unsigned a, o, lim, off, room;
      logic [1:0]  lanes;
      a = addr;
      if (byte_acc) a[0] = 1'b0;
      lanes = byte_acc ? (addr[0] ? 2'b01 : 2'b10) : 2'b11;
      tgt  = TGT_UNMAPPED;
      off  = 0;
      room = 0;
      if (a < RamSize) begin
        tgt  = TGT_RAM;
        off  = a;
        room = RamSize - a;
      end else if (a >= ProgBase && a < ProgBase + ProgSpan) begin
        o   = a - ProgBase;
        lim = (prog_size < ProgSpan) ? prog_size : ProgSpan;
        if (o < lim) begin
          tgt  = TGT_PROG;
          off  = o;
          room = lim - o;
        end
      end else if (a >= SmpBase && a < SmpBase + SmpSpan) begin
        o = a - SmpBase;
        map_sample(o, SmpSpan - o, tgt, off, room);
      end else if (a >= BankABase && a < BankABase + BankASpan) begin
        o = a - BankABase;
        map_sample((bank_dflt ? BankADflt : BankAUpper) + o, BankASpan - o, tgt, off, room);
      end else if (a >= BankBBase) begin
        o = a - BankBBase;
        map_sample((bank_dflt ? BankBDflt : BankBUpper) + o, BankBSpan - o, tgt, off, room);
      end else if (a >= ChipBase && a < ChipBase + ChipSize) begin
        tgt  = TGT_CHIP;
        off  = (a - ChipBase) >> 1;
        room = 2;
      end else if (a >= CtrlBase && a < CtrlBase + 2) begin
        tgt = TGT_CTRL;
      end

      res               = '0;
      res.target        = tgt;
      res.target_offset = AddrW'(off);
      if (tgt <= TGT_CHIP) begin
        res.lane_mask = lanes;
        // only the high byte is left at a window end
        if (room < 2) res.lane_mask[0] = 1'b0;
      end
      if (wr == FnWrite) begin
        if (tgt == TGT_CTRL && smp_size > BankLimit) bank_dflt = wd[BankBit];
        if ((tgt == TGT_RAM || tgt == TGT_CHIP) && res.lane_mask != 2'b00) begin
          res.store_enable = 1'b1;
          if (byte_acc == AccWord) res.store_data = wd;
          else if (addr[0])        res.store_data = {8'h00, wd[7:0]};
          else                     res.store_data = {wd[7:0], 8'h00};
        end
      end
      n_per_tgt[tgt]++;
      pending_decodes.push_back(res);
    endfunction

    function void compare_field(input string name, input int unsigned exp_v,
                                input int unsigned act_v);
      if (exp_v != act_v) begin
        n_err++;
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      end
    endfunction

    function void check_result(input logic [47:0] data, input logic [2:0] user);
      dec_res_t exp_r;
      if (pending_decodes.size() == 0) begin
        n_err++;
        $error("decode result with no access outstanding");
        return;
      end
      exp_r = pending_decodes.pop_front();
      n_checked++;
      compare_field("target",        exp_r.target,        user);
      compare_field("target_offset", exp_r.target_offset, data[23:0]);
      compare_field("lane_mask",     exp_r.lane_mask,     data[25:24]);
      compare_field("store_enable",  exp_r.store_enable,  data[26]);
      compare_field("store_data",    exp_r.store_data,    data[42:27]);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [SmpSizeW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [39:0]          s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [47:0]          m_axis_tdata;
  logic [2:0]           m_axis_tuser;

  decode_checker sb = new;
  int unsigned   src_idle_pct  = 0;
  int unsigned   sink_stall_pct = 0;

  sound_bus_address_decoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // entered and left at a falling edge; tvalid stays high on return
  task automatic send_access(input logic wr, input logic byte_acc,
                             input logic [AddrW-1:0] addr, input logic [DataW-1:0] wd);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wd, addr};
    s_axis_tuser  <= {byte_acc, wr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_access(wr, byte_acc, addr, wd);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [SmpSizeW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_SAMPLE_ROM_SIZE) sb.smp_size = val;
    else                            sb.prog_size = val[ProgSizeW-1:0];
    @(negedge clk_i);
  endtask

  task automatic set_rom_sizes(input logic [SmpSizeW-1:0] smp, input logic [ProgSizeW-1:0] prog);
    cfg_write(CFG_SAMPLE_ROM_SIZE, smp);
    cfg_write(CFG_PROGRAM_ROM_SIZE, {5'b0, prog});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_decodes.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // biased toward window edges and the ends of the configured ROMs
  function automatic logic [AddrW-1:0] pick_address();
    int unsigned sel, near, win, full;
    sel  = $urandom_range(12);
    near = $urandom_range(3);
    full = $urandom_range(24'hffffff);
    case (sel)
      0:  pick_address = AddrW'($urandom_range(RamSize - 1));
      1:  pick_address = AddrW'(RamSize - 1 - near);
      2:  pick_address = AddrW'(ChipBase + $urandom_range(ChipSize - 1));
      3:  pick_address = AddrW'(CtrlBase + near);
      4:  pick_address = AddrW'(ProgBase + $urandom_range(ProgSpan - 1));
      5:  pick_address = AddrW'(ProgBase + sb.prog_size - 1 + $urandom_range(2) - near);
      6:  pick_address = AddrW'(SmpBase + $urandom_range(SmpSpan - 1));
      7:  pick_address = AddrW'(BankABase + $urandom_range(BankASpan - 1));
      8:  pick_address = AddrW'(BankBBase + $urandom_range(BankBSpan - 1));
      9: begin
        win = $urandom_range(2);
        if (win == 0)      full = SmpBase + sb.smp_size;
        else if (win == 1) full = BankABase + sb.smp_size - (sb.bank_dflt ? BankADflt : BankAUpper);
        else               full = BankBBase + sb.smp_size - (sb.bank_dflt ? BankBDflt : BankBUpper);
        pick_address = AddrW'(full - 1 + $urandom_range(2) - near);
      end
      10: begin
        win = $urandom_range(2);
        pick_address = AddrW'((win == 0) ? SmpBase + SmpSpan - 1 - near :
                              (win == 1) ? BankABase + BankASpan - 1 - near :
                                           24'hffffff - near);
      end
      default: pick_address = AddrW'(full);
    endcase
  endfunction

  logic [SmpSizeW-1:0]  smp_sets[8]  = '{25'h1000000, 25'h0000000, 25'h0800000, 25'h0800001,
                                          25'h0a00001, 25'h0000000, 25'h1000000, 25'h0c00000};
  logic [ProgSizeW-1:0] prog_sets[8] = '{20'h80000, 20'h00000, 20'h7ffff, 20'h12345,
                                          20'h00003, 20'h00000, 20'h00001, 20'h80000};

  initial begin
    logic [SmpSizeW-1:0]  smp;
    logic [ProgSizeW-1:0] prog;
    int unsigned          n_items;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // odd sizes so both ROM windows end on a lone high byte; banking enabled
    set_rom_sizes(25'h0ffffff, 20'h07fff);
    send_access(FnRead,  AccWord, 24'h000000, 16'h0000);
    send_access(FnWrite, AccWord, 24'h000001, 16'hffff);
    send_access(FnWrite, AccByte, 24'h07ffff, 16'h12a5);
    send_access(FnWrite, AccByte, 24'h07fffe, 16'h345a);
    send_access(FnWrite, AccWord, 24'h07ffff, 16'hbeef);
    send_access(FnWrite, AccWord, 24'h100000, 16'h1234);
    send_access(FnWrite, AccWord, 24'h100fff, 16'h8001);
    send_access(FnWrite, AccByte, 24'h100ffe, 16'hffff);
    send_access(FnRead,  AccWord, 24'h600000, 16'h0000);
    send_access(FnWrite, AccWord, 24'h607ffe, 16'hcafe);
    send_access(FnRead,  AccByte, 24'h607fff, 16'h0000);
    send_access(FnRead,  AccWord, 24'h608000, 16'h0000);
    send_access(FnWrite, AccByte, 24'h600001, 16'h00ff);
    send_access(FnRead,  AccWord, 24'h400000, 16'h0000);
    send_access(FnWrite, AccWord, 24'h400001, 16'hffdf);  // upper banks
    send_access(FnRead,  AccWord, 24'ha00000, 16'h0000);
    send_access(FnRead,  AccWord, 24'he00000, 16'h0000);
    send_access(FnWrite, AccByte, 24'h400000, 16'h0020);  // default banks
    send_access(FnRead,  AccWord, 24'ha00000, 16'h0000);
    send_access(FnRead,  AccByte, 24'hffffff, 16'h0000);
    send_access(FnWrite, AccWord, 24'hffffff, 16'hffff);
    send_access(FnRead,  AccWord, 24'h9fffff, 16'h0000);
    send_access(FnRead,  AccWord, 24'h080000, 16'h0000);
    send_access(FnWrite, AccWord, 24'h400002, 16'hffff);
    send_access(FnRead,  AccWord, 24'h8a0000, 16'h0000);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      smp  = smp_sets[ph];
      prog = prog_sets[ph];
      if (ph == 5) begin
        smp  = SmpSizeW'($urandom_range(25'h1000000));
        prog = ProgSizeW'($urandom_range(20'h80000));
      end
      set_rom_sizes(smp, prog);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      for (n_items = 0; n_items < PhaseItems; n_items++) begin
        send_access(1'($urandom_range(1)), 1'($urandom_range(1)), pick_address(),
                    DataW'($urandom_range(16'hffff)));
      end
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("checked %0d decodes over 9 ROM size settings and 4 flow-control mixes",
             sb.n_checked);
    $display("by target ram/prog/sample/chip/ctrl/unmapped: %0d/%0d/%0d/%0d/%0d/%0d",
             sb.n_per_tgt[0], sb.n_per_tgt[1], sb.n_per_tgt[2], sb.n_per_tgt[3],
             sb.n_per_tgt[4], sb.n_per_tgt[5]);
    if (sb.n_err == 0 && sb.pending_decodes.size() == 0) begin
      $display("sound_bus_address_decoder_core: match");
    end else begin
      $display("sound_bus_address_decoder_core: mismatch");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("timeout waiting for decode results");
    $display("sound_bus_address_decoder_core: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sbad_pkg.sv
hw/rtl/sbad_decode.sv
hw/rtl/sound_bus_address_decoder_core.sv
dv/tb_sound_bus_address_decoder_core.sv
